// ===== design/sdbd_pkg.sv =====
// Shared types and fixed constants of the SSD detection box decoder.
// Used by the decoder core and by its port checker; depends on nothing else.

package sdbd_pkg;

    // Fixed field widths.
    localparam int RAW_W      = 16;
    localparam int FIDX_W     = 16;
    localparam int GROW_W     = 16;
    localparam int GROW_FRAC  = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_X       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_Y       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCORE_THR    = 3'd4;

    // Sequencer steps of one record.
    localparam int STEP_W = 3;
    localparam logic [STEP_W-1:0] STEP_GROW_X = 3'd4;
    localparam logic [STEP_W-1:0] STEP_GROW_Y = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FIN_X  = 3'd5;
    localparam logic [STEP_W-1:0] STEP_FIN_Y  = 3'd6;
    localparam logic [STEP_W-1:0] STEP_LAST   = 3'd6;

    // Number of corner entries in the coordinate and pixel registers.
    localparam int N_CORNERS = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_EMIT
    } t_state;

endpackage

// ===== design/ssd_detection_box_decode_core.sv =====
// Top level of the SSD detection box decoder: clamp, scale, grow and clip of one box.
// Depends on sdbd_pkg; all multiplications go through one shared multiplier.

// A live record is decoded from the cycle it is accepted until the decoder is
// ready again: the acceptance cycle, seven steps of the sequencer around the
// single shared 14x16 multiplier (four corner scalings, two growth products,
// and the clip of each axis in the step after its product), and an emit state
// that loads the output register if the box passes the score and area check.
// o_ready is low during that time, and the output load waits while a previous
// result still sits unread in the output register. Records that carry the end
// mark, or that arrive after one up to and including the frame's last slot,
// are dropped in their acceptance cycle and keep o_ready high. Configuration
// writes are taken in any cycle and should be made only while the decoder is idle.

module ssd_detection_box_decode_core
    import sdbd_pkg::*;
#(
    parameter int FRAME_BITS = 13,
    parameter int FRAC_BITS  = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write channel
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    // record input channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [FIDX_W-1:0]       i_frame_index,
    input  logic                    i_end_mark,
    input  logic                    i_last_slot,
    input  logic signed [RAW_W-1:0] i_score_raw,
    input  logic signed [RAW_W-1:0] i_left_raw,
    input  logic signed [RAW_W-1:0] i_top_raw,
    input  logic signed [RAW_W-1:0] i_right_raw,
    input  logic signed [RAW_W-1:0] i_bottom_raw,
    // box output channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [FIDX_W-1:0]       o_out_frame_index,
    output logic [FRAC_BITS:0]      o_confidence,
    output logic [FRAME_BITS-1:0]   o_box_x,
    output logic [FRAME_BITS-1:0]   o_box_y,
    output logic [FRAME_BITS:0]     o_box_w,
    output logic [FRAME_BITS:0]     o_box_h
);

    localparam int SW  = FRAME_BITS + 1;
    localparam int VW  = FRAC_BITS + 1;
    localparam int MA  = (VW > SW) ? VW : SW;
    localparam int MB  = (SW > GROW_W) ? SW : GROW_W;
    localparam int PW  = MA + MB;
    localparam int MW  = SW + 1 + GROW_FRAC;
    localparam int EW  = ((MW > PW) ? MW : PW) + 2;
    localparam int SHR = GROW_FRAC + 1;

    localparam logic [PW-1:0]         PIX_RND  = PW'(1) << (FRAC_BITS - 1);
    localparam logic signed [EW-1:0]  CEIL_ADD = (EW'(1) << SHR) - EW'(1);
    localparam logic signed [RAW_W+1:0] ONE_S  = (RAW_W+2)'(1) << FRAC_BITS;

    // Configuration registers.
    logic [SW-1:0]     r_frame_w;
    logic [SW-1:0]     r_frame_h;
    logic [GROW_W-1:0] r_grow_x;
    logic [GROW_W-1:0] r_grow_y;
    logic [VW-1:0]     r_thr;

    // Sequencer and record registers.
    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_ended;
    logic [FIDX_W-1:0] r_fidx;
    logic [VW-1:0]     r_conf;
    logic [VW-1:0]     r_v   [N_CORNERS];
    logic [SW-1:0]     r_pix [N_CORNERS];
    logic [PW-1:0]     r_prod;
    logic [SW-1:0]     r_x, r_y, r_w, r_h;

    // Output register.
    logic              r_ov;
    logic [FIDX_W-1:0] r_o_fidx;
    logic [VW-1:0]     r_o_conf;
    logic [SW-1:0]     r_o_x, r_o_y, r_o_w, r_o_h;

    logic              in_fire;
    logic              live;
    logic              emit_ok;
    logic              out_free;
    logic              out_load;
    logic [VW-1:0]     clamp_in [N_CORNERS + 1];
    logic signed [RAW_W-1:0] raw_in [N_CORNERS + 1];

    logic [MA-1:0]     mul_a;
    logic [MB-1:0]     mul_b;
    logic [SW-1:0]     iss_p0, iss_p1, iss_diff;
    logic [SW-1:0]     fin_p0, fin_p1, fin_lo_pix, fin_hi_pix, fin_size;
    logic [SW-1:0]     pix_new;
    logic signed [EW-1:0] mid_s, ext_s, lo_full, hi_full, size_s, size_m1;
    logic signed [EW-1:0] lo_c, hi_c, side_c;
    logic [STEP_W-1:0] cons_idx;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == ST_IDLE);
    assign in_fire     = i_valid && o_ready;
    assign live        = !r_ended && !i_end_mark;

    // Clamp the score and the four corners to [0, 1].
    assign raw_in[0] = i_left_raw;
    assign raw_in[1] = i_right_raw;
    assign raw_in[2] = i_top_raw;
    assign raw_in[3] = i_bottom_raw;
    assign raw_in[4] = i_score_raw;

    always_comb begin
        for (int k = 0; k < N_CORNERS + 1; k++) begin
            if (raw_in[k] < 0) begin
                clamp_in[k] = '0;
            end else if ((RAW_W+2)'(raw_in[k]) > ONE_S) begin
                clamp_in[k] = VW'(ONE_S);
            end else begin
                clamp_in[k] = VW'(raw_in[k]);
            end
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        iss_p0   = (r_step == STEP_GROW_Y) ? r_pix[2] : r_pix[0];
        iss_p1   = (r_step == STEP_GROW_Y) ? r_pix[3] : r_pix[1];
        iss_diff = (iss_p0 < iss_p1) ? (iss_p1 - iss_p0) : (iss_p0 - iss_p1);
        mul_a    = '0;
        mul_b    = '0;
        unique case (r_step)
            3'd0, 3'd1: begin
                mul_a = MA'(r_v[r_step[1:0]]);
                mul_b = MB'(r_frame_w);
            end
            3'd2, 3'd3: begin
                mul_a = MA'(r_v[r_step[1:0]]);
                mul_b = MB'(r_frame_h);
            end
            STEP_GROW_X: begin
                mul_a = MA'(iss_diff);
                mul_b = MB'(r_grow_x);
            end
            STEP_GROW_Y: begin
                mul_a = MA'(iss_diff);
                mul_b = MB'(r_grow_y);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Rounded pixel from the previous product.
    assign pix_new  = SW'((r_prod + PIX_RND) >> FRAC_BITS);
    assign cons_idx = r_step - STEP_W'(1);

    // Grow about the center and clip, from the previous growth product.
    always_comb begin
        fin_p0     = (r_step == STEP_FIN_Y) ? r_pix[2] : r_pix[0];
        fin_p1     = (r_step == STEP_FIN_Y) ? r_pix[3] : r_pix[1];
        fin_size   = (r_step == STEP_FIN_Y) ? r_frame_h : r_frame_w;
        fin_lo_pix = (fin_p0 < fin_p1) ? fin_p0 : fin_p1;
        fin_hi_pix = (fin_p0 < fin_p1) ? fin_p1 : fin_p0;
        mid_s   = signed'(EW'({(SW+1)'(fin_lo_pix) + (SW+1)'(fin_hi_pix), GROW_FRAC'(0)}));
        ext_s   = signed'(EW'(r_prod));
        lo_full = (mid_s - ext_s) >>> SHR;
        hi_full = (mid_s + ext_s + CEIL_ADD) >>> SHR;
        size_s  = signed'(EW'(fin_size));
        size_m1 = size_s - EW'(1);

        lo_c = lo_full;
        if (lo_c > size_m1) begin
            lo_c = size_m1;
        end
        if (lo_c < 0) begin
            lo_c = '0;
        end
        hi_c = hi_full;
        if (hi_c > size_s) begin
            hi_c = size_s;
        end
        if (hi_c < 0) begin
            hi_c = '0;
        end
        side_c = (hi_c > lo_c) ? (hi_c - lo_c) : '0;
    end

    assign emit_ok  = (r_conf > r_thr) && (r_w != '0) && (r_h != '0);
    assign out_free = !r_ov || i_ready;
    assign out_load = (r_state == ST_EMIT) && emit_ok && out_free;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            ST_IDLE: begin
                n_step = '0;
                if (in_fire && live) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_EMIT;
                    n_step  = '0;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_EMIT: begin
                // A box is dropped at once; a kept box waits for the output register.
                if (!emit_ok || out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_w <= SW'(1920);
            r_frame_h <= SW'(1080);
            r_grow_x  <= GROW_W'(1) << GROW_FRAC;
            r_grow_y  <= GROW_W'(1) << GROW_FRAC;
            r_thr     <= VW'(1) << (FRAC_BITS - 1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_w <= i_cfg_data[SW-1:0];
                CFG_FRAME_HEIGHT: r_frame_h <= i_cfg_data[SW-1:0];
                CFG_GROW_X:       r_grow_x  <= i_cfg_data[GROW_W-1:0];
                CFG_GROW_Y:       r_grow_y  <= i_cfg_data[GROW_W-1:0];
                CFG_SCORE_THR:    r_thr     <= i_cfg_data[VW-1:0];
                default:          ;
            endcase
        end
    end

    // The end mark holds until the frame's last slot has been seen.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ended <= 1'b0;
        end else if (in_fire) begin
            r_ended <= i_last_slot ? 1'b0 : (r_ended || i_end_mark);
        end
    end

    // Record datapath.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_fidx <= i_frame_index;
            r_conf <= clamp_in[4];
            for (int k = 0; k < N_CORNERS; k++) begin
                r_v[k] <= clamp_in[k];
            end
        end
        if (r_state == ST_RUN) begin
            r_prod <= PW'(mul_a) * PW'(mul_b);
            if (r_step != '0) begin
                if (cons_idx < STEP_W'(N_CORNERS)) begin
                    r_pix[cons_idx[1:0]] <= pix_new;
                end else if (r_step == STEP_FIN_X) begin
                    r_x <= lo_c[SW-1:0];
                    r_w <= side_c[SW-1:0];
                end else begin
                    r_y <= lo_c[SW-1:0];
                    r_h <= side_c[SW-1:0];
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (out_load) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_fidx <= r_fidx;
            r_o_conf <= r_conf;
            r_o_x    <= r_x;
            r_o_y    <= r_y;
            r_o_w    <= r_w;
            r_o_h    <= r_h;
        end
    end

    assign o_valid           = r_ov;
    assign o_out_frame_index = r_o_fidx;
    assign o_confidence      = r_o_conf;
    assign o_box_x           = r_o_x[FRAME_BITS-1:0];
    assign o_box_y           = r_o_y[FRAME_BITS-1:0];
    assign o_box_w           = r_o_w;
    assign o_box_h           = r_o_h;

endmodule

// ===== design/sdbd_checker.sv =====
// Port-level checker for the SSD detection box decoder, bound to its top level.
// Depends on sdbd_pkg and sees only the ports of ssd_detection_box_decode_core.

module sdbd_checker
    import sdbd_pkg::*;
#(
    parameter int FRAME_BITS = 13,
    parameter int FRAC_BITS  = 12
) (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    i_valid,
    input logic                    o_ready,
    input logic                    i_end_mark,
    input logic                    o_valid,
    input logic                    i_ready,
    input logic [FIDX_W-1:0]       o_out_frame_index,
    input logic [FRAC_BITS:0]      o_confidence,
    input logic [FRAME_BITS-1:0]   o_box_x,
    input logic [FRAME_BITS-1:0]   o_box_y,
    input logic [FRAME_BITS:0]     o_box_w,
    input logic [FRAME_BITS:0]     o_box_h
);

    localparam logic [FRAC_BITS:0] CONF_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    // A stalled result keeps its valid and its box.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_box_x) && $stable(o_box_y)
            && $stable(o_box_w) && $stable(o_box_h) && $stable(o_confidence)
            && $stable(o_out_frame_index))
        else $error("output transaction changed while stalled");

    // Only boxes with area are delivered.
    a_box_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_box_w != '0) && (o_box_h != '0))
        else $error("box with zero side delivered");

    // The delivered confidence exceeds some threshold and is clamped to one.
    a_conf_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_confidence != '0) && (o_confidence <= CONF_ONE))
        else $error("confidence out of range");

    // After reset the decoder is idle with an empty output register.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("decoder not idle after reset");

    // An end-marked record is dropped without starting the sequencer.
    a_end_mark_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_end_mark |=> o_ready)
        else $error("end-marked record started a decode");

endmodule

bind ssd_detection_box_decode_core sdbd_checker #(
    .FRAME_BITS(FRAME_BITS),
    .FRAC_BITS (FRAC_BITS)
) u_sdbd_checker (.*);

// ===== dv/tb_ssd_detection_box_decode_core.sv =====
// Self-checking testbench for ssd_detection_box_decode_core: directed rows, then random frames.
// Depends on sdbd_pkg and the decoder core; box predictions come from a local integer model.

module tb_ssd_detection_box_decode_core;
    import sdbd_pkg::*;

    localparam int FRAME_BITS = 13;
    localparam int FRAC_BITS  = 12;

    localparam longint Q_UNIT    = longint'(1) << FRAC_BITS;
    localparam longint HALF_LSB  = longint'(1) << (FRAC_BITS - 1);
    localparam longint GROW_UNIT = longint'(1) << GROW_FRAC;
    localparam longint GROW_DEN  = longint'(2) << GROW_FRAC;

    localparam logic [RAW_W-1:0] Q_ONE   = 16'h1000;
    localparam logic [RAW_W-1:0] Q_HALF  = 16'h0800;
    localparam logic [RAW_W-1:0] RAW_MAX = 16'h7FFF;
    localparam logic [RAW_W-1:0] RAW_MIN = 16'h8000;

    // Index outside the register list; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    localparam int N_DIR         = 30;
    localparam int N_PHASES      = 8;
    localparam int HOLD_PHASE    = 1;
    localparam int PAUSE_PHASE   = 3;
    localparam int LONG_HOLD     = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int LIMIT_CYCLES  = 500000;
    localparam int MAX_PRINTS    = 200;

    typedef struct packed {
        logic [FIDX_W-1:0] fidx;
        logic              endm;
        logic              last;
        logic [RAW_W-1:0]  score;
        logic [RAW_W-1:0]  left;
        logic [RAW_W-1:0]  top;
        logic [RAW_W-1:0]  right;
        logic [RAW_W-1:0]  bottom;
    } rec_t;

    typedef struct packed {
        logic [FIDX_W-1:0]     fidx;
        logic [FRAC_BITS:0]    conf;
        logic [FRAME_BITS-1:0] x;
        logic [FRAME_BITS-1:0] y;
        logic [FRAME_BITS:0]   w;
        logic [FRAME_BITS:0]   h;
    } box_t;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        rec_t                  item;
        bit                    fixed;
        bit                    emit;
        box_t                  box;
    } dir_row_t;

    typedef struct {
        logic [CFG_DATA_W-1:0] fw;
        logic [CFG_DATA_W-1:0] fh;
        logic [CFG_DATA_W-1:0] gx;
        logic [CFG_DATA_W-1:0] gy;
        logic [CFG_DATA_W-1:0] thr;
        int                    quota;
        bit                    rnd;
    } phase_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_DATA_W-1:0]   i_cfg_data = '0;
    logic                    i_valid = 1'b0;
    logic                    o_ready;
    logic [FIDX_W-1:0]       i_frame_index = '0;
    logic                    i_end_mark = 1'b0;
    logic                    i_last_slot = 1'b0;
    logic signed [RAW_W-1:0] i_score_raw = '0;
    logic signed [RAW_W-1:0] i_left_raw = '0;
    logic signed [RAW_W-1:0] i_top_raw = '0;
    logic signed [RAW_W-1:0] i_right_raw = '0;
    logic signed [RAW_W-1:0] i_bottom_raw = '0;
    logic                    o_valid;
    logic                    i_ready = 1'b0;
    logic [FIDX_W-1:0]       o_out_frame_index;
    logic [FRAC_BITS:0]      o_confidence;
    logic [FRAME_BITS-1:0]   o_box_x;
    logic [FRAME_BITS-1:0]   o_box_y;
    logic [FRAME_BITS:0]     o_box_w;
    logic [FRAME_BITS:0]     o_box_h;

    // Predictor copy of the registers and of the end-of-detections flag.
    logic [FRAME_BITS:0]  cfg_fw = 14'd1920;
    logic [FRAME_BITS:0]  cfg_fh = 14'd1080;
    logic [GROW_W-1:0]    cfg_gx = 16'd4096;
    logic [GROW_W-1:0]    cfg_gy = 16'd4096;
    logic [FRAC_BITS:0]   cfg_thr = 13'd2048;
    bit                   frame_done = 1'b0;

    box_t        boxes_due[$];
    int          err_count = 0;
    int unsigned cycle_n = 0;
    bit          rx_hold_req = 1'b0;
    bit          rx_calm = 1'b0;

    dir_row_t dir_rows [N_DIR];
    phase_t   phases [N_PHASES];

    ssd_detection_box_decode_core #(
        .FRAME_BITS(FRAME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_frame_index    (i_frame_index),
        .i_end_mark       (i_end_mark),
        .i_last_slot      (i_last_slot),
        .i_score_raw      (i_score_raw),
        .i_left_raw       (i_left_raw),
        .i_top_raw        (i_top_raw),
        .i_right_raw      (i_right_raw),
        .i_bottom_raw     (i_bottom_raw),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_frame_index(o_out_frame_index),
        .o_confidence     (o_confidence),
        .o_box_x          (o_box_x),
        .o_box_y          (o_box_y),
        .o_box_w          (o_box_w),
        .o_box_h          (o_box_h)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unit_clamp(input logic [RAW_W-1:0] raw);
        longint v;
        v = longint'($signed(raw));
        if (v < 0) return 0;
        if (v > Q_UNIT) return Q_UNIT;
        return v;
    endfunction

    // Scale both edges of one axis, order them, grow about the center and clip.
    function automatic longint axis_span(input logic [RAW_W-1:0] raw0, input logic [RAW_W-1:0] raw1,
                                         input longint size, input longint grow,
                                         output longint side);
        longint p0, p1, a, b, mid, ext, num, lo, hi;
        p0 = (unit_clamp(raw0) * size + HALF_LSB) >>> FRAC_BITS;
        p1 = (unit_clamp(raw1) * size + HALF_LSB) >>> FRAC_BITS;
        a = (p0 < p1) ? p0 : p1;
        b = (p0 < p1) ? p1 : p0;
        mid = (a + b) * GROW_UNIT;
        ext = (b - a) * grow;
        num = mid - ext;
        lo = num / GROW_DEN;
        if (num % GROW_DEN != 0 && num < 0) lo = lo - 1;
        num = mid + ext;
        hi = num / GROW_DEN;
        if (num % GROW_DEN != 0 && num > 0) hi = hi + 1;
        if (lo > size - 1) lo = size - 1;
        if (lo < 0) lo = 0;
        if (hi > size) hi = size;
        if (hi < 0) hi = 0;
        side = (hi > lo) ? hi - lo : 0;
        return lo;
    endfunction

    // Returns 1 when the record yields a box; also advances the end-mark state.
    function automatic bit decode_box(input rec_t r, output box_t b, output bit live);
        longint conf, x, y, w, h;
        live = !frame_done && !r.endm;
        frame_done = r.last ? 1'b0 : (frame_done || r.endm);
        b = '0;
        if (!live) return 1'b0;
        conf = unit_clamp(r.score);
        x = axis_span(r.left, r.right, longint'(cfg_fw), longint'(cfg_gx), w);
        y = axis_span(r.top, r.bottom, longint'(cfg_fh), longint'(cfg_gy), h);
        b.fidx = r.fidx;
        b.conf = (FRAC_BITS + 1)'(conf);
        b.x    = FRAME_BITS'(x);
        b.y    = FRAME_BITS'(y);
        b.w    = (FRAME_BITS + 1)'(w);
        b.h    = (FRAME_BITS + 1)'(h);
        return (conf > longint'(cfg_thr)) && (w > 0) && (h > 0);
    endfunction

    function automatic dir_row_t rec(input logic [FIDX_W-1:0] fidx, input bit endm,
                                     input bit last, input logic [RAW_W-1:0] sc,
                                     input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] t,
                                     input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] bt);
        dir_row_t d;
        d.is_cfg = 1'b0;
        d.idx    = CFG_FRAME_WIDTH;
        d.data   = '0;
        d.item   = {fidx, endm, last, sc, l, t, r, bt};
        d.fixed  = 1'b0;
        d.emit   = 1'b0;
        d.box    = '0;
        return d;
    endfunction

    function automatic dir_row_t rec_none(input logic [FIDX_W-1:0] fidx, input bit endm,
                                          input bit last, input logic [RAW_W-1:0] sc,
                                          input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] t,
                                          input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] bt);
        dir_row_t d;
        d = rec(fidx, endm, last, sc, l, t, r, bt);
        d.fixed = 1'b1;
        return d;
    endfunction

    function automatic dir_row_t rec_box(input logic [FIDX_W-1:0] fidx, input bit endm,
                                         input bit last, input logic [RAW_W-1:0] sc,
                                         input logic [RAW_W-1:0] l, input logic [RAW_W-1:0] t,
                                         input logic [RAW_W-1:0] r, input logic [RAW_W-1:0] bt,
                                         input int conf, input int x, input int y,
                                         input int w, input int h);
        dir_row_t d;
        d = rec(fidx, endm, last, sc, l, t, r, bt);
        d.fixed = 1'b1;
        d.emit  = 1'b1;
        d.box   = {fidx, (FRAC_BITS + 1)'(conf), FRAME_BITS'(x), FRAME_BITS'(y),
                   (FRAME_BITS + 1)'(w), (FRAME_BITS + 1)'(h)};
        return d;
    endfunction

    function automatic dir_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
        dir_row_t d;
        d = rec('0, 1'b0, 1'b0, '0, '0, '0, '0, '0);
        d.is_cfg = 1'b1;
        d.idx    = idx;
        d.data   = data;
        return d;
    endfunction

    function automatic logic [RAW_W-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0:       return Q_ONE;
            1:       return '0;
            2, 3:    return RAW_W'($urandom);
            default: return RAW_W'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic logic [RAW_W-1:0] rand_score();
        // Scores right around the threshold exercise the strict comparison.
        if ($urandom_range(0, 3) == 0)
            return RAW_W'(cfg_thr) + RAW_W'($urandom_range(0, 2)) - RAW_W'(1);
        return rand_coord();
    endfunction

    task automatic report_mismatch(input string msg);
        err_count++;
        // Keep the log short when the block is badly broken.
        if (err_count <= MAX_PRINTS) $display("MISMATCH at cycle %0d: %s", cycle_n, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want) report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    // Offers one record and waits for its transaction; the caller lowers valid if needed.
    task automatic offer(input rec_t item, input bit fixed, input bit fixed_emit,
                         input box_t fixed_box, output bit live);
        box_t b;
        bit   emit;
        i_valid       <= 1'b1;
        i_frame_index <= item.fidx;
        i_end_mark    <= item.endm;
        i_last_slot   <= item.last;
        i_score_raw   <= item.score;
        i_left_raw    <= item.left;
        i_top_raw     <= item.top;
        i_right_raw   <= item.right;
        i_bottom_raw  <= item.bottom;
        do @(posedge i_clk); while (!o_ready);
        emit = decode_box(item, b, live);
        if (fixed) begin
            emit = fixed_emit;
            b    = fixed_box;
        end
        if (emit) boxes_due.push_back(b);
    endtask

    // Leaves cfg valid high; the caller lowers it after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_FRAME_WIDTH:  cfg_fw  = data[FRAME_BITS:0];
            CFG_FRAME_HEIGHT: cfg_fh  = data[FRAME_BITS:0];
            CFG_GROW_X:       cfg_gx  = data[GROW_W-1:0];
            CFG_GROW_Y:       cfg_gy  = data[GROW_W-1:0];
            CFG_SCORE_THR:    cfg_thr = data[FRAC_BITS:0];
            default: ;
        endcase
    endtask

    // Stops offering until every pending box is out, then lets a dropped record finish.
    task automatic drain();
        i_valid <= 1'b0;
        while (boxes_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        box_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (boxes_due.size() == 0) begin
                report_mismatch($sformatf("unexpected box for frame %0d", o_out_frame_index));
            end else begin
                want = boxes_due.pop_front();
                check_field("frame_index", o_out_frame_index, want.fidx);
                check_field("confidence", o_confidence, want.conf);
                check_field("box_x", o_box_x, want.x);
                check_field("box_y", o_box_y, want.y);
                check_field("box_w", o_box_w, want.w);
                check_field("box_h", o_box_h, want.h);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_n = cycle_n + 1;
        if (cycle_n >= LIMIT_CYCLES) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : rx_side
        int span;
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                i_ready <= 1'b0;
                span = LONG_HOLD;
            end else if (rx_calm) begin
                i_ready <= 1'b1;
                span = 1;
            end else if ($urandom_range(0, 2) == 0) begin
                i_ready <= 1'b0;
                span = $urandom_range(1, 19);
            end else begin
                i_ready <= 1'b1;
                span = $urandom_range(1, 24);
            end
            repeat (span) @(posedge i_clk);
        end
    end

    initial begin : stim
        bit                live;
        int                live_n;
        int                frame_n;
        int                nrec;
        int                end_at;
        int                rush;
        logic [FIDX_W-1:0] fidx;
        rec_t              item;
        phase_t            cur;

        dir_rows = '{
            rec_box(16'h0000, 1'b0, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE,
                    4096, 0, 0, 1920, 1080),
            rec_none(16'h0001, 1'b0, 1'b0, Q_HALF, '0, '0, Q_ONE, Q_ONE),
            rec_box(16'h0002, 1'b0, 1'b0, 16'h0801, '0, '0, Q_ONE, Q_ONE,
                    2049, 0, 0, 1920, 1080),
            rec_box(16'hFFFF, 1'b0, 1'b0, RAW_MAX, RAW_MIN, RAW_MIN, RAW_MAX, RAW_MAX,
                    4096, 0, 0, 1920, 1080),
            rec_none(16'h0004, 1'b0, 1'b0, RAW_MIN, '0, '0, Q_ONE, Q_ONE),
            rec(16'h0005, 1'b0, 1'b0, 16'h0C00, Q_ONE, Q_ONE, '0, '0),
            rec_none(16'h0006, 1'b0, 1'b0, Q_ONE, Q_HALF, '0, Q_HALF, Q_ONE),
            rec(16'h0007, 1'b0, 1'b0, 16'h0A00, 16'h0123, 16'h0456, 16'h0BCD, 16'h0E01),
            rec_none(16'h0008, 1'b1, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            rec_none(16'h0009, 1'b0, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            rec_none(16'h000A, 1'b0, 1'b1, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            rec_box(16'h000B, 1'b0, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE,
                    4096, 0, 0, 1920, 1080),
            rec_none(16'h000C, 1'b1, 1'b1, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            rec(16'h000D, 1'b0, 1'b1, 16'h0FFF, 16'h0400, 16'h0400, 16'h0C00, 16'h0C00),
            cfg_row(CFG_UNUSED, 16'hFFFF),
            rec(16'h000E, 1'b0, 1'b0, 16'h0900, 16'h0200, 16'h0300, 16'h0D00, 16'h0F00),
            cfg_row(CFG_GROW_X, 16'hFFFF),
            cfg_row(CFG_GROW_Y, 16'h0000),
            rec(16'h0010, 1'b0, 1'b0, Q_ONE, 16'h0600, 16'h0600, 16'h0A00, 16'h0A00),
            rec(16'h0011, 1'b0, 1'b0, Q_ONE, 16'h0100, 16'h0100, 16'h0E00, 16'h0E00),
            cfg_row(CFG_SCORE_THR, 16'h1FFF),
            rec_none(16'h0012, 1'b0, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            cfg_row(CFG_SCORE_THR, 16'h0000),
            cfg_row(CFG_FRAME_WIDTH, 16'h0000),
            rec_none(16'h0013, 1'b0, 1'b0, Q_ONE, '0, '0, Q_ONE, Q_ONE),
            cfg_row(CFG_FRAME_WIDTH, 16'h3FFF),
            cfg_row(CFG_FRAME_HEIGHT, 16'h2000),
            cfg_row(CFG_GROW_Y, 16'h1000),
            rec(16'h0014, 1'b0, 1'b0, 16'h0001, Q_HALF, '0, Q_ONE, Q_ONE),
            rec(16'h0015, 1'b0, 1'b1, 16'h0001, '0, '0, Q_ONE, Q_ONE)
        };

        // Quotas count live records; ended records come on top, about 1000 in all.
        phases = '{
            '{16'd1920, 16'd1080, 16'd4096,  16'd4096,  16'd2048, 110, 1'b0},
            '{16'd640,  16'd480,  16'd6144,  16'd2048,  16'd1000, 110, 1'b0},
            '{16'd1,    16'd1,    16'd4096,  16'd4096,  16'd0,    70,  1'b0},
            '{16'd8192, 16'd8192, 16'd65535, 16'd0,     16'd4095, 110, 1'b0},
            '{16'hFFFF, 16'd12000, 16'd8192, 16'd12288, 16'd3000, 70,  1'b0},
            '{16'd0,    16'd300,  16'd4096,  16'd4096,  16'd100,  35,  1'b0},
            '{16'd320,  16'd8192, 16'd0,     16'd65535, 16'hFFFF, 35,  1'b0},
            '{16'd0,    16'd0,    16'd0,     16'd0,     16'd0,    180, 1'b1}
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
                i_cfg_valid <= 1'b0;
            end else begin
                offer(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].emit,
                      dir_rows[i].box, live);
            end
        end

        foreach (phases[p]) begin
            cur = phases[p];
            if (cur.rnd) begin
                cur.fw  = CFG_DATA_W'($urandom_range(1, 8192));
                cur.fh  = CFG_DATA_W'($urandom_range(1, 8192));
                cur.gx  = CFG_DATA_W'($urandom_range(2048, 12288));
                cur.gy  = CFG_DATA_W'($urandom_range(2048, 12288));
                cur.thr = CFG_DATA_W'($urandom_range(0, 4096));
            end
            // The final phase runs with no idling on either side.
            rx_calm = (p == N_PHASES - 1);
            drain();
            write_reg(CFG_FRAME_WIDTH, cur.fw);
            write_reg(CFG_FRAME_HEIGHT, cur.fh);
            write_reg(CFG_GROW_X, cur.gx);
            write_reg(CFG_GROW_Y, cur.gy);
            write_reg(CFG_SCORE_THR, cur.thr);
            i_cfg_valid <= 1'b0;

            live_n  = 0;
            frame_n = 0;
            rush    = 0;
            while (live_n < cur.quota) begin
                nrec   = $urandom_range(1, 12);
                end_at = $urandom_range(0, 1) ? $urandom_range(0, nrec - 1) : nrec;
                fidx   = FIDX_W'($urandom);
                if (p == HOLD_PHASE && frame_n == 4) begin
                    // Receiver stalls for a long time while records keep coming.
                    rx_hold_req = 1'b1;
                    rush = 16;
                end
                if (p == PAUSE_PHASE && frame_n == 4) drain();
                for (int k = 0; k < nrec; k++) begin
                    item.fidx   = fidx;
                    item.endm   = (k == end_at);
                    item.last   = (k == nrec - 1);
                    // Occasionally break the frame structure.
                    if ($urandom_range(0, 19) == 0) item.endm = ~item.endm;
                    if ($urandom_range(0, 19) == 0) item.last = ~item.last;
                    item.score  = rand_score();
                    item.left   = rand_coord();
                    item.top    = rand_coord();
                    item.right  = rand_coord();
                    item.bottom = rand_coord();
                    if (rush > 0) begin
                        rush--;
                    end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
                        i_valid <= 1'b0;
                        repeat ($urandom_range(1, 19)) @(posedge i_clk);
                    end
                    offer(item, 1'b0, 1'b0, '0, live);
                    if (live) live_n++;
                end
                frame_n++;
            end
        end

        drain();
        if (err_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
